/* src/sdq_pkg.sv */
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants for the double-ended store with positional insert.
// ----------------------------------------------------------------------------
package sdq_pkg;

    // Store geometry. DEPTH is a power of two so that ring addresses wrap freely.
    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // Operation codes carried by an item.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_POP_FRONT   = 3'd1,
        OP_PEEK_FRONT  = 3'd2,
        OP_INSERT      = 3'd3,
        OP_APPEND_BACK = 3'd4,
        OP_REMOVE_BACK = 3'd5
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS
    } state_t;

endpackage

/* src/stack_deque_with_positional_insert.sv */
// ----------------------------------------------------------------------------
// stack_deque_with_positional_insert
// Bounded ordered store of signed 32-bit values kept as a ring in one RAM.
// ----------------------------------------------------------------------------
// Push, append, rejected writes, empty reads and unknown codes finish in the
// cycle after acceptance; pop, peek and remove pass first through the
// registered RAM read and the read state. A middle insert moves each
// displaced entry by one RAM read and one RAM write through the single
// port pair, then writes the value. One item at a time, busy while in work.
// Reset clears the count, head pointer and sequencer; RAM contents are left.
module stack_deque_with_positional_insert
    import sdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic               was_empty,
    output logic               rejected_full,
    output logic [4:0]         entry_count
);

    // Storage ring and its read data register.
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   idx_reg, idx_next;
    op_t             op_reg, op_next;
    logic [31:0]     value_reg, value_next;
    logic            done_reg, done_next;
    logic [31:0]     res_reg, res_next;
    logic            empty_reg, empty_next;
    logic            full_reg, full_next;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic [AW-1:0]   raddr;
    logic            accept;
    logic [CW-1:0]   ins_idx;
    logic [CW-1:0]   i_dec;
    op_t             op_in;

    assign accept = start && (state_reg == ST_IDLE);
    assign op_in  = op_t'(operation);
    assign i_dec  = i_reg - CW'(1);

    // Insert index: clamp(position-1, 1, count).
    always_comb
    begin
        if (position <= 5'd2)
            ins_idx = CW'(1);
        else
            ins_idx = CW'(position - 5'd1);
        if (ins_idx > count_reg)
            ins_idx = count_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op_in == OP_POP_FRONT || op_in == OP_PEEK_FRONT ||
                         op_in == OP_REMOVE_BACK) && count_reg != '0)
                        state_next = ST_READ;
                    else if (op_in == OP_INSERT && count_reg != '0 &&
                             count_reg != CW'(DEPTH) && ins_idx != count_reg)
                        state_next = ST_SH_RD;
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_SH_RD: state_next = ST_SH_WR;
            ST_SH_WR: state_next = (i_dec == idx_reg) ? ST_INS : ST_SH_RD;
            ST_INS:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        empty_next = empty_reg;
        full_next  = full_reg;
        we         = 1'b0;
        waddr      = head_reg;
        wdata      = value_reg;
        raddr      = head_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_in;
                    value_next = value;
                    res_next   = '0;
                    empty_next = 1'b0;
                    full_next  = 1'b0;
                    unique case (op_in)
                        OP_PUSH_FRONT, OP_INSERT, OP_APPEND_BACK:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                full_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else if (op_in == OP_PUSH_FRONT || count_reg == '0)
                            begin
                                we         = 1'b1;
                                waddr      = head_reg - AW'(1);
                                wdata      = value;
                                head_next  = head_reg - AW'(1);
                                count_next = count_reg + CW'(1);
                                done_next  = 1'b1;
                            end
                            else if (op_in == OP_APPEND_BACK || ins_idx == count_reg)
                            begin
                                we         = 1'b1;
                                waddr      = head_reg + count_reg[AW-1:0];
                                wdata      = value;
                                count_next = count_reg + CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                i_next   = count_reg;
                                idx_next = ins_idx;
                            end
                        end
                        OP_POP_FRONT, OP_PEEK_FRONT, OP_REMOVE_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '1;
                                empty_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else if (op_in == OP_REMOVE_BACK)
                                raddr = head_reg + count_reg[AW-1:0] - AW'(1);
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                res_next  = rdata_reg;
                done_next = 1'b1;
                if (op_reg == OP_POP_FRONT)
                begin
                    head_next  = head_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                end
                else if (op_reg == OP_REMOVE_BACK)
                    count_next = count_reg - CW'(1);
            end
            ST_SH_RD:
                raddr = head_reg + i_dec[AW-1:0];
            ST_SH_WR:
            begin
                we     = 1'b1;
                waddr  = head_reg + i_reg[AW-1:0];
                wdata  = rdata_reg;
                i_next = i_dec;
            end
            ST_INS:
            begin
                we         = 1'b1;
                waddr      = head_reg + idx_reg[AW-1:0];
                wdata      = value_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
            end
            default: ;
        endcase
    end

    // Ring memory with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        idx_reg   <= idx_next;
        op_reg    <= op_next;
        value_reg <= value_next;
        res_reg   <= res_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
    end

    // Ports.
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign result_value  = res_reg;
    assign was_empty     = empty_reg;
    assign rejected_full = full_reg;
    assign entry_count   = 5'(count_reg);

endmodule

/* src/sdq_checker.sv */
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks for the double-ended store, bound to the top level.
// ----------------------------------------------------------------------------
module sdq_checker
    import sdq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] result_value,
    input logic               was_empty,
    input logic               rejected_full,
    input logic [4:0]         entry_count
);

    // Every accepted item either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither finished nor in work");

    // The count never exceeds the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entry_count <= 5'(DEPTH))
        else $error("entry count beyond depth");

    // A rejected write only happens when the store is full.
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected_full |-> entry_count == 5'(DEPTH) && !was_empty)
        else $error("write rejected on a store that is not full");

    // An empty read leaves the store empty and returns minus one.
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_empty |-> entry_count == 5'd0 && result_value == -32'sd1)
        else $error("empty read reported wrongly");

endmodule

bind stack_deque_with_positional_insert sdq_checker u_sdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .result_value  (result_value),
    .was_empty     (was_empty),
    .rejected_full (rejected_full),
    .entry_count   (entry_count)
);
